@@ design/assert_macros.svh @@
// Assertion macros used by the datapath of the decimal text unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/stdt_pkg.sv @@
// Types and constants of the sample to decimal text unit.
`default_nettype none

package stdt_pkg;

  // Depth mode register codes; the fourth code has no meaning and emits nothing.
  localparam logic [1:0] DepthMode8    = 2'd0;
  localparam logic [1:0] DepthMode16   = 2'd1;
  localparam logic [1:0] DepthModeNone = 2'd2;

  // Characters.
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharNewline = 8'h0A;

  // Digit storage: a 16-bit value has at most five decimal digits.
  localparam int unsigned MaxDigits = 5;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned CntW      = 3;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned NarrowW   = 8;

  // Reciprocal of ten: (x * 52429) >> 19 equals x / 10 for every 16-bit x.
  localparam logic [SampleW-1:0] Div10Mul   = 16'd52429;
  localparam int unsigned        Div10Shift = 19;
  localparam int unsigned        QuotW      = 2 * SampleW - Div10Shift;

  // Input beat.
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               line_end;
  } sample_in_t;

  // Output beat.
  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } text_out_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIGITS,
    ST_SPACE,
    ST_NEWLINE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_digit;
    logic emit_space;
    logic emit_newline;
  } stdt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode_ok;
    logic conv_last;
    logic digit_last;
    logic line_end;
    logic out_free;
  } stdt_status_t;

endpackage

`default_nettype wire

@@ design/stdt_ctrl.sv @@
// Controller state machine of the sample to decimal text unit.
`default_nettype none

module stdt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  stdt_pkg::stdt_status_t status_i,
  output stdt_pkg::stdt_cmd_t    cmd_o
);
  import stdt_pkg::*;

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.mode_ok) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (status_i.conv_last) begin
          state_d = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (status_i.out_free && status_i.digit_last) begin
          state_d = ST_SPACE;
        end
      end
      ST_SPACE: begin
        if (status_i.out_free) begin
          state_d = status_i.line_end ? ST_NEWLINE : ST_IDLE;
        end
      end
      ST_NEWLINE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
      end
      ST_DIGITS: begin
        cmd_o.emit_digit = status_i.out_free;
      end
      ST_SPACE: begin
        cmd_o.emit_space = status_i.out_free;
      end
      ST_NEWLINE: begin
        cmd_o.emit_newline = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/stdt_dp.sv @@
// Datapath of the sample to decimal text unit: divide by ten, digit store, output register.
`default_nettype none
`include "assert_macros.svh"

module stdt_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stdt_pkg::sample_in_t   in_data_i,
  input  logic                   cfg_valid_i,
  input  logic [1:0]             cfg_data_i,
  input  stdt_pkg::stdt_cmd_t    cmd_i,
  output stdt_pkg::stdt_status_t status_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output stdt_pkg::text_out_t    out_data_o
);
  import stdt_pkg::*;

  logic [1:0]              depth_mode_q;
  logic [SampleW-1:0]      value_q;
  logic [SampleW-1:0]      value_masked;
  logic [DigitW-1:0]       digit_q [MaxDigits];
  logic [CntW-1:0]         cnt_q;
  logic [CntW-1:0]         rd_idx;
  logic                    line_end_q;
  logic                    out_valid_q;
  text_out_t               out_data_q;
  text_out_t               out_data_d;
  logic                    out_load;
  logic [2*SampleW-1:0]    prod;
  logic [QuotW-1:0]        quot;
  logic [SampleW-1:0]      quot_ext;
  logic [SampleW-1:0]      times10;
  logic [SampleW-1:0]      rem_full;
  logic [DigitW-1:0]       digit_new;
  logic [DigitW-1:0]       digit_sel;

  // Sample masking by depth mode.
  always_comb begin
    if (depth_mode_q == DepthMode8) begin
      value_masked = {{(SampleW-NarrowW){1'b0}}, in_data_i.sample[NarrowW-1:0]};
    end else begin
      value_masked = in_data_i.sample;
    end
  end

  // One division by ten per cycle through the reciprocal product.
  always_comb begin
    prod      = (2*SampleW)'(value_q) * (2*SampleW)'(Div10Mul);
    quot      = prod[2*SampleW-1:Div10Shift];
    quot_ext  = {{(SampleW-QuotW){1'b0}}, quot};
    times10   = (quot_ext << 3) + (quot_ext << 1);
    rem_full  = value_q - times10;
    digit_new = rem_full[DigitW-1:0];
  end

  // Most significant remaining digit sits just below the count.
  assign rd_idx    = cnt_q - CntW'(1);
  assign digit_sel = digit_q[rd_idx];

  // Status toward the controller.
  assign out_load            = !out_valid_q || out_ready_i;
  assign status_o.mode_ok    = (depth_mode_q == DepthMode8) || (depth_mode_q == DepthMode16);
  assign status_o.conv_last  = (quot == '0);
  assign status_o.digit_last = (cnt_q == CntW'(1));
  assign status_o.line_end   = line_end_q;
  assign status_o.out_free   = out_load;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_mode_q <= DepthMode8;
    end else if (cfg_valid_i) begin
      depth_mode_q <= cfg_data_i;
    end
  end

  // Working value, line flag and digit store; digits land least significant first.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q    <= value_masked;
      line_end_q <= in_data_i.line_end;
    end else if (cmd_i.conv_step) begin
      value_q        <= quot_ext;
      digit_q[cnt_q] <= digit_new;
    end
  end

  // Digit count: up while converting, down while emitting.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.conv_step) begin
      cnt_q <= cnt_q + CntW'(1);
    end else if (cmd_i.emit_digit) begin
      cnt_q <= rd_idx;
    end
  end

  // Character for the next output beat.
  always_comb begin
    out_data_d = out_data_q;
    if (cmd_i.emit_digit) begin
      out_data_d.text_char = CharZero + {{(8-DigitW){1'b0}}, digit_sel};
      out_data_d.last_char = 1'b0;
    end else if (cmd_i.emit_space) begin
      out_data_d.text_char = CharSpace;
      out_data_d.last_char = !line_end_q;
    end else if (cmd_i.emit_newline) begin
      out_data_d.text_char = CharNewline;
      out_data_d.last_char = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_digit || cmd_i.emit_space || cmd_i.emit_newline) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The controller issues at most one command per cycle.
  `ASSERT_ALWAYS(a_cmd_onehot, clk_i, rst_ni, $onehot0(cmd_i))
  // A character is only written when the output register is free.
  `ASSERT_IMPLIES(a_emit_free, clk_i, rst_ni,
    cmd_i.emit_digit || cmd_i.emit_space || cmd_i.emit_newline, out_load)
  // A digit is only emitted while digits remain.
  `ASSERT_IMPLIES(a_digit_left, clk_i, rst_ni, cmd_i.emit_digit, cnt_q != '0)
  // The digit count never passes the digit store depth.
  `ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(MaxDigits))

endmodule

`default_nettype wire

@@ design/sample_to_decimal_text_unit.sv @@
// Top level of the sample to decimal text unit: controller plus datapath.
//
// Usage: each input beat on in_valid_i/in_ready_o carries one sample and a
// line_end flag. The unit sends the sample's unsigned decimal text, one ASCII
// character per output beat on out_valid_o/out_ready_i: the digits without
// leading zeros, then a space, then a newline when line_end is set.
// last_char marks the final character of each sample.
// depth_mode is written on the cfg channel, which is always ready; it selects
// 8-bit samples (code 0), 16-bit samples (code 1) or no output (other codes).
// Write it only while the unit is idle.
// Sequence: the input is taken in the idle state, then the divide-by-ten unit
// produces the digits, then the characters drain through the output
// register. Samples in an unsupported mode are taken and dropped. The next
// sample is taken while the last character still waits in the output
// register. A stalled receiver holds the sequencer.
// Reset returns the unit to idle, clears the output valid and sets depth_mode
// to 8-bit samples.
`default_nettype none

module sample_to_decimal_text_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  stdt_pkg::sample_in_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stdt_pkg::text_out_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_data_i
);
  import stdt_pkg::*;

  stdt_cmd_t    cmd;
  stdt_status_t status;

  // The configuration register accepts a write in every cycle.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  stdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Conversion and output datapath.
  stdt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ tb/sample_to_decimal_text_unit_test.sv @@
// Self-checking testbench for the sample to decimal text unit.
`timescale 1ns / 1ps

module sample_to_decimal_text_unit_test;
  import stdt_pkg::*;

  // The depth code that has no meaning; the unit must drop its samples.
  localparam logic [1:0] DepthModeUnused = 2'd3;
  // Cycles to let an item with no output finish before a register write.
  localparam int SettleCycles = 16;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int StallLimit = 2000;
  localparam int RandomPerMode16 = 105;
  localparam int RandomPerMode8 = 25;
  localparam int RandomPerModeOff = 6;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  sample_in_t in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  text_out_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i = '0;

  // Mirror of the depth register, the beats waiting to be sent and the text still owed.
  logic [1:0] depth_mirror = DepthMode8;
  sample_in_t pending_beats_q[$];
  text_out_t  expected_chars_q[$];
  text_out_t  want_char;
  bit         in_fire = 1'b0;
  int         sender_idle_pct = 0;
  int         receiver_idle_pct = 0;
  int         fail_count = 0;
  int         quiet_cycles = 0;

  sample_to_decimal_text_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Free-running clock, 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Appends the characters that one accepted sample must produce.
  function automatic void queue_decimal_text(sample_in_t beat, logic [1:0] mode);
    logic [15:0] value;
    logic [3:0]  digits [MaxDigits];
    int          n;
    text_out_t   ch;
    case (mode)
      DepthMode8:  value = {8'h00, beat.sample[7:0]};
      DepthMode16: value = beat.sample;
      default:     return;
    endcase
    n = 0;
    do begin
      digits[n] = 4'(value % 16'd10);
      value = value / 16'd10;
      n++;
    end while (value != 16'd0 && n < MaxDigits);
    for (int i = n - 1; i >= 0; i--) begin
      ch.text_char = CharZero + 8'(digits[i]);
      ch.last_char = 1'b0;
      expected_chars_q.push_back(ch);
    end
    ch.text_char = CharSpace;
    ch.last_char = !beat.line_end;
    expected_chars_q.push_back(ch);
    if (beat.line_end) begin
      ch.text_char = CharNewline;
      ch.last_char = 1'b1;
      expected_chars_q.push_back(ch);
    end
  endfunction

  // Builds a random sample whose digit count is spread evenly, with some raw noise.
  function automatic sample_in_t random_sample_beat();
    sample_in_t beat;
    case ($urandom_range(0, 5))
      0:       beat.sample = 16'($urandom_range(0, 9));
      1:       beat.sample = 16'($urandom_range(10, 99));
      2:       beat.sample = 16'($urandom_range(100, 999));
      3:       beat.sample = 16'($urandom_range(1000, 9999));
      4:       beat.sample = 16'($urandom_range(10000, 65535));
      default: beat.sample = 16'($urandom());
    endcase
    beat.line_end = ($urandom_range(0, 3) == 0);
    return beat;
  endfunction

  task automatic push_beat(input logic [15:0] sample, input logic line_end);
    sample_in_t beat;
    beat.sample = sample;
    beat.line_end = line_end;
    pending_beats_q.push_back(beat);
  endtask

  // Waits until every beat is sent and every character has arrived, then lets
  // a dropped sample still inside the unit finish.
  task automatic wait_idle();
    while (pending_beats_q.size() != 0 || in_valid_i || expected_chars_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the depth register once the unit has gone quiet.
  task automatic write_depth(input logic [1:0] mode);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_random(input int count);
    repeat (count) pending_beats_q.push_back(random_sample_beat());
  endtask

  // Input driver: holds a beat until it is taken, otherwise sends or idles.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (pending_beats_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_beats_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output receiver: stalls at random.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // Monitor: predicts on every accepted sample and checks every output beat.
  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        depth_mirror = cfg_data_i;
      end
      if (in_fire) begin
        queue_decimal_text(in_data_i, depth_mirror);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_chars_q.size() == 0) begin
          $error("unexpected output beat: text_char 0x%02h, last_char %0b",
                 out_data_o.text_char, out_data_o.last_char);
          fail_count++;
        end else begin
          want_char = expected_chars_q.pop_front();
          if (out_data_o.text_char !== want_char.text_char) begin
            $error("text_char: expected 0x%02h, got 0x%02h",
                   want_char.text_char, out_data_o.text_char);
            fail_count++;
          end
          if (out_data_o.last_char !== want_char.last_char) begin
            $error("last_char: expected %0b, got %0b",
                   want_char.last_char, out_data_o.last_char);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no channel moves a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("** sample_to_decimal_text_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset depth is 8-bit: digit-count boundaries and ignored high bits.
    push_beat(16'd0, 1'b0);
    push_beat(16'd9, 1'b1);
    push_beat(16'd10, 1'b0);
    push_beat(16'd255, 1'b1);
    push_beat(16'h01FF, 1'b0);
    push_beat(16'hFF00, 1'b1);

    // 16-bit samples across every digit count up to full scale.
    write_depth(DepthMode16);
    push_beat(16'd0, 1'b1);
    push_beat(16'd1, 1'b0);
    push_beat(16'd99, 1'b0);
    push_beat(16'd100, 1'b1);
    push_beat(16'd999, 1'b0);
    push_beat(16'd1000, 1'b0);
    push_beat(16'd9999, 1'b1);
    push_beat(16'd10000, 1'b0);
    push_beat(16'd65535, 1'b1);
    push_beat(16'd65535, 1'b0);
    push_beat(16'd32768, 1'b0);

    // Unsupported depth and the meaningless code both drop every sample.
    write_depth(DepthModeNone);
    push_beat(16'd123, 1'b1);
    push_beat(16'hFFFF, 1'b0);
    write_depth(DepthModeUnused);
    push_beat(16'd7, 1'b0);
    push_beat(16'hFFFF, 1'b1);

    // Random phases: receiver idles more, then sender idles more, then no idling.
    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          sender_idle_pct = 22;
          receiver_idle_pct = 57;
        end
        1: begin
          sender_idle_pct = 57;
          receiver_idle_pct = 22;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      write_depth(DepthMode16);
      push_random(RandomPerMode16);
      write_depth(DepthMode8);
      push_random(RandomPerMode8);
      write_depth(phase == 1 ? DepthModeUnused : DepthModeNone);
      push_random(RandomPerModeOff);
    end

    wait_idle();
    if (fail_count == 0 && expected_chars_q.size() == 0) begin
      $display("** sample_to_decimal_text_unit: PASSED **");
    end else begin
      $display("** sample_to_decimal_text_unit: FAILED **");
    end
    $finish;
  end

endmodule
